// ===== hdl/gswcpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gswcpm_pkg: shared types and constants for the sliding-window CPM core
// Field widths and the saturation limit of the counts-per-minute reading.
// ----------------------------------------------------------------------------
package gswcpm_pkg;

  localparam int CNT_W   = 16;
  localparam int CPM_W   = 20;
  localparam int TOTAL_W = 32;

  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [CPM_W-1:0]   cpm_t;
  typedef logic [TOTAL_W-1:0] total_t;

  localparam cpm_t CPM_MAX = {CPM_W{1'b1}};

endpackage

// ===== hdl/geiger_sliding_window_cpm_core.sv =====
`timescale 1ns / 1ps
// An accepted input word passes through the input register, then the result register.
// Throughput: one word per cycle while result_stall is low, set by the running-sum update.
// The ring memory reads the next oldest count one word ahead, so no read waits.
// Reset (rst, synchronous): clears sum, total, peak, uptime, position and warm-up
// count at once; the ring itself is not cleared, unwritten entries are masked.
// ----------------------------------------------------------------------------
// geiger_sliding_window_cpm_core: sliding-window counts per minute
// Sums the last WINDOW interval counts and tracks total, peak and uptime.
// ----------------------------------------------------------------------------
module geiger_sliding_window_cpm_core #(
  parameter int WINDOW           = 12,
  parameter int SECONDS_PER_ITEM = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  gswcpm_pkg::count_t    interval_count,
  output logic                  result_valid,
  input  logic                  result_stall,
  output gswcpm_pkg::cpm_t      counts_per_minute,
  output gswcpm_pkg::total_t    running_total,
  output gswcpm_pkg::cpm_t      peak_cpm,
  output logic                  reading_valid,
  output gswcpm_pkg::total_t    uptime_seconds
);
  import gswcpm_pkg::*;

  // Exact sum width: WINDOW counts of CNT_W bits each.
  localparam int SUM_W  = CNT_W + $clog2(WINDOW);
  localparam int CMP_W  = (SUM_W > CPM_W) ? SUM_W : CPM_W;
  localparam int POS_W  = $clog2(WINDOW);
  localparam int WARM_W = $clog2(WINDOW + 1);
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW - 1);
  localparam logic [WARM_W-1:0] WARM_FULL = WARM_W'(WINDOW);
  localparam total_t            STEP      = TOTAL_W'(SECONDS_PER_ITEM);

  // Input register: one word of buffering in front of the update logic.
  logic   item_full;
  count_t item_count;
  logic   item_accept;
  logic   advance;

  // Window state.
  count_t            ring [WINDOW];
  count_t            oldest;
  logic [POS_W-1:0]  ring_position;
  logic [POS_W-1:0]  ring_position_next;
  logic [SUM_W-1:0]  window_sum;
  logic [SUM_W-1:0]  window_sum_next;
  logic [WARM_W-1:0] warmup_items;
  logic              warm_done;
  count_t            oldest_use;
  logic [CMP_W-1:0]  sum_cmp;
  cpm_t              cpm;
  cpm_t              peak_next;

  // Move the held word into the result register whenever that register is
  // empty or being drained this cycle.
  assign advance     = item_full && (!result_valid || !result_stall);
  assign item_stall  = item_full && !advance;
  assign item_accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_accept) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      item_count <= interval_count;
    end
  end

  // Until the ring has wrapped once, the entry being overwritten was never
  // written and counts as zero.
  assign warm_done          = (warmup_items == WARM_FULL);
  assign oldest_use         = warm_done ? oldest : '0;
  assign ring_position_next = (ring_position == POS_LAST) ? '0 : ring_position + 1'b1;
  assign window_sum_next    = window_sum - SUM_W'(oldest_use) + SUM_W'(item_count);

  // Saturate the reading at the field limit.
  assign sum_cmp   = CMP_W'(window_sum_next);
  assign cpm       = (sum_cmp > CMP_W'(CPM_MAX)) ? CPM_MAX : CPM_W'(sum_cmp);
  assign peak_next = (cpm > peak_cpm) ? cpm : peak_cpm;

  // Ring memory: write the new count, prefetch the entry that the next word
  // will overwrite. Addresses always differ when WINDOW is at least two.
  always_ff @(posedge clk) begin
    if (advance) begin
      ring[ring_position] <= item_count;
      oldest              <= ring[ring_position_next];
    end
  end

  // Control and accumulated state; total, peak and uptime drive the ports.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid   <= 1'b0;
      ring_position  <= '0;
      window_sum     <= '0;
      warmup_items   <= '0;
      running_total  <= '0;
      peak_cpm       <= '0;
      uptime_seconds <= '0;
    end else begin
      if (advance) begin
        result_valid   <= 1'b1;
        ring_position  <= ring_position_next;
        window_sum     <= window_sum_next;
        running_total  <= running_total + TOTAL_W'(item_count);
        peak_cpm       <= peak_next;
        uptime_seconds <= uptime_seconds + STEP;
        if (!warm_done) begin
          warmup_items <= warmup_items + 1'b1;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload: hold while stalled, load on advance.
  always_ff @(posedge clk) begin
    if (advance) begin
      counts_per_minute <= cpm;
      reading_valid     <= warm_done && (cpm != '0);
    end
  end

`ifndef SYNTHESIS
  a_peak_covers_cpm: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> peak_cpm >= counts_per_minute)
    else $error("peak_cpm below counts_per_minute");

  a_valid_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && reading_valid) |-> counts_per_minute != '0)
    else $error("reading_valid with zero counts_per_minute");

  a_warmup_void: assert property (@(posedge clk) disable iff (rst)
    (advance && !warm_done) |=> !reading_valid)
    else $error("reading_valid during warm-up");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    ring_position <= POS_LAST)
    else $error("ring_position out of range");

  a_uptime_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> uptime_seconds == $past(uptime_seconds) + STEP)
    else $error("uptime did not advance by one step");
`endif

endmodule

// ===== dv/geiger_sliding_window_cpm_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geiger_sliding_window_cpm_core_test: self-checking bench for the CPM core
// Feeds interval counts through a directed plan, a backpressure phase,
// segmented random traffic and a long back-to-back burst of full counts.
// Every result word is checked against a local predictor or a typed plan row.
// ----------------------------------------------------------------------------
module geiger_sliding_window_cpm_core_test;
  import gswcpm_pkg::*;

  localparam int WINDOW           = 12;
  localparam int SECONDS_PER_ITEM = 5;
  localparam int PERIOD_NS        = 8;
  localparam int RESET_CYCLES     = 8;
  localparam int IDLE_PCT         = 31;
  localparam int HOLD_CYCLES      = 60;
  localparam int PRESSURE_WORDS   = 20;
  localparam int RANDOM_WORDS     = 300;
  localparam int BURST_WORDS      = 60;
  localparam int SETTLE_CYCLES    = 8;
  localparam int QUIET_LIMIT      = 1000;
  localparam int PLAN_ROWS        = 25;

  // one result word as the block presents it
  typedef struct packed {
    cpm_t   cpm;
    total_t total;
    cpm_t   peak;
    logic   valid;
    total_t uptime;
  } reading_t;

  // directed plan: a count, and the full result where it is obvious
  typedef struct packed {
    count_t   count;
    logic     typed;
    reading_t want;
  } plan_row_t;

  typedef enum int {MIX_FULL, MIX_LOW, MIX_ZERO, MIX_HIGH, MIX_ONEHOT} mix_t;

  localparam count_t CNT_MAX = {CNT_W{1'b1}};

  // Warm-up from reset with extreme counts, the first full window at the
  // largest possible sum, then a window of zeros that voids the reading.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{16'd0,  1'b1, '{20'd0,      32'd0,      20'd0,      1'b0, 32'd5}},
    '{CNT_MAX, 1'b1, '{20'd65535,  32'd65535,  20'd65535,  1'b0, 32'd10}},
    '{CNT_MAX, 1'b0, '0}, '{CNT_MAX, 1'b0, '0}, '{CNT_MAX, 1'b0, '0},
    '{CNT_MAX, 1'b0, '0}, '{CNT_MAX, 1'b0, '0}, '{CNT_MAX, 1'b0, '0},
    '{CNT_MAX, 1'b0, '0}, '{CNT_MAX, 1'b0, '0}, '{CNT_MAX, 1'b0, '0},
    '{CNT_MAX, 1'b0, '0},
    '{CNT_MAX, 1'b1, '{20'd786420, 32'd786420, 20'd786420, 1'b1, 32'd65}},
    '{16'd0, 1'b0, '0}, '{16'd0, 1'b0, '0}, '{16'd0, 1'b0, '0},
    '{16'd0, 1'b0, '0}, '{16'd0, 1'b0, '0}, '{16'd0, 1'b0, '0},
    '{16'd0, 1'b0, '0}, '{16'd0, 1'b0, '0}, '{16'd0, 1'b0, '0},
    '{16'd0, 1'b0, '0}, '{16'd0, 1'b0, '0},
    '{16'd0,  1'b1, '{20'd0,      32'd786420, 20'd786420, 1'b0, 32'd125}}
  };

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   item_valid = 1'b0;
  logic   item_stall;
  count_t interval_count = '0;
  logic   result_valid;
  logic   result_stall = 1'b0;
  cpm_t   counts_per_minute;
  total_t running_total;
  cpm_t   peak_cpm;
  logic   reading_valid;
  total_t uptime_seconds;

  geiger_sliding_window_cpm_core #(
    .WINDOW           (WINDOW),
    .SECONDS_PER_ITEM (SECONDS_PER_ITEM)
  ) u_top (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .interval_count    (interval_count),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .counts_per_minute (counts_per_minute),
    .running_total     (running_total),
    .peak_cpm          (peak_cpm),
    .reading_valid     (reading_valid),
    .uptime_seconds    (uptime_seconds)
  );

  initial begin
    forever #(PERIOD_NS / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the window ring, its exact sum and the long-run trackers
  // --------------------------------------------------------------------------
  count_t      ring_q [WINDOW] = '{default: '0};
  int unsigned ring_idx        = 0;
  int unsigned warm_cnt        = 0;
  logic [31:0] window_acc      = '0;
  total_t      total_acc       = '0;
  cpm_t        peak_acc        = '0;
  total_t      uptime_acc      = '0;

  reading_t reading_q [$];
  int       mismatch_cnt = 0;
  bit       tx_idle_on   = 1'b1;
  bit       rx_idle_on   = 1'b1;
  int       hold_asked   = 0;

  // Advance the window by one interval count and return the reading it gives.
  function automatic reading_t cpm_after(count_t c);
    reading_t r;
    // drop the oldest count, add the new one; the sum is kept exactly
    window_acc = window_acc - 32'(ring_q[ring_idx]) + 32'(c);
    ring_q[ring_idx] = c;
    ring_idx = (ring_idx == WINDOW - 1) ? 0 : ring_idx + 1;
    r.cpm = (window_acc > CPM_MAX) ? CPM_MAX : window_acc[CPM_W-1:0];
    total_acc  = total_acc + 32'(c);
    uptime_acc = uptime_acc + SECONDS_PER_ITEM;
    if (r.cpm > peak_acc) peak_acc = r.cpm;
    // void through warm-up, then void only on an empty window
    if (warm_cnt < WINDOW) begin
      r.valid = 1'b0;
      warm_cnt++;
    end else begin
      r.valid = (r.cpm != '0);
    end
    r.total  = total_acc;
    r.peak   = peak_acc;
    r.uptime = uptime_acc;
    return r;
  endfunction

  // Present one word and hold it until the block takes it. Idle gaps come
  // only before valid rises, so valid never reacts to stall.
  task automatic offer_word(input count_t c);
    while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid     <= 1'b1;
    interval_count <= c;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic feed_count(input count_t c);
    offer_word(c);
    reading_q.push_back(cpm_after(c));
  endtask

  // Lower valid and hold the sender until every expected word is back.
  task automatic drain_results();
    item_valid <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk);
  endtask

  function automatic void field_check(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off when the stimulus asks
  // --------------------------------------------------------------------------
  int hold_granted = 0;
  int hold_left    = 0;

  always @(posedge clk) begin
    if (hold_granted != hold_asked) begin
      hold_granted = hold_asked;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= rx_idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Result check against the oldest expectation, plus the stuck-run watchdog
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    reading_t want;
    if (!rst && result_valid && !result_stall) begin
      if (reading_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result word with nothing expected, cpm %0d", $time,
                 counts_per_minute);
      end else begin
        want = reading_q.pop_front();
        field_check("counts_per_minute", 32'(want.cpm), 32'(counts_per_minute));
        field_check("running_total", want.total, running_total);
        field_check("peak_cpm", 32'(want.peak), 32'(peak_cpm));
        field_check("reading_valid", 32'(want.valid), 32'(reading_valid));
        field_check("uptime_seconds", want.uptime, uptime_seconds);
      end
    end
    // count cycles in which neither channel moves a word
    if ((item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    reading_t got_pred;
    mix_t     mix;
    int       run_len;
    int       fed;
    count_t   c;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed plan: typed rows still advance the predictor so it stays aligned.
    for (int i = 0; i < PLAN_ROWS; i++) begin
      offer_word(PLAN[i].count);
      got_pred = cpm_after(PLAN[i].count);
      reading_q.push_back(PLAN[i].typed ? PLAN[i].want : got_pred);
    end

    // Backpressure: hold the receiver off while words keep coming so the
    // block fills and stalls its input, then pause until all words are back.
    hold_asked++;
    for (int i = 0; i < PRESSURE_WORDS; i++) feed_count(count_t'($urandom_range(0, 65535)));
    drain_results();

    // Random traffic in segments of one flavor each; zero runs are long
    // enough to empty the window again.
    fed = 0;
    while (fed < RANDOM_WORDS) begin
      mix     = mix_t'($urandom_range(0, 4));
      run_len = (mix == MIX_ZERO) ? $urandom_range(WINDOW, WINDOW + 8) : $urandom_range(4, 30);
      repeat (run_len) begin
        case (mix)
          MIX_FULL:   c = count_t'($urandom_range(0, 65535));
          MIX_LOW:    c = count_t'($urandom_range(0, 15));
          MIX_ZERO:   c = '0;
          MIX_HIGH:   c = CNT_MAX - count_t'($urandom_range(0, 15));
          MIX_ONEHOT: c = count_t'(1) << $urandom_range(0, CNT_W - 1);
          default:    c = '0;
        endcase
        feed_count(c);
        fed++;
      end
    end

    // Back-to-back burst of full counts with no idling on either side,
    // then a few random words.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (BURST_WORDS) feed_count(CNT_MAX);
    repeat (4) feed_count(count_t'($urandom_range(0, 65535)));

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && reading_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gswcpm_pkg.sv
hdl/geiger_sliding_window_cpm_core.sv
dv/geiger_sliding_window_cpm_core_test.sv
